// ===== sv/isrf_pkg.sv =====
// Shared types and constants for the image scale, rotate and flip block.
package isrf_pkg;

    // Field widths
    localparam int PIX_W      = 24;
    localparam int COORD_W    = 11;
    localparam int DIM_W      = 9;
    localparam int SCALE_W    = 4;
    localparam int TURN_W     = 2;
    localparam int SCALED_W   = 13;   // width * scale: 511 * 15 fits in 13 bits
    localparam int FS_W       = 18;   // width * height: 511 * 511 fits in 18 bits

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes
    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_SCALE      = 3'd2,
        REG_TURNS      = 3'd3,
        REG_VMIRROR    = 3'd4,
        REG_HMIRROR    = 3'd5
    } reg_idx_t;

    // Counterclockwise quarter turns
    typedef enum logic [1:0] {
        TURN_0   = 2'd0,
        TURN_90  = 2'd1,
        TURN_180 = 2'd2,
        TURN_270 = 2'd3
    } turn_t;

    // One input item
    typedef struct packed {
        logic                command;
        logic [PIX_W-1:0]    pixel_value;
        logic [COORD_W-1:0]  target_row;
        logic [COORD_W-1:0]  target_column;
    } req_item_t;

    // One result item
    typedef struct packed {
        logic [PIX_W-1:0]    result_pixel;
        logic                outside_frame;
    } rsp_item_t;

    // Raw register contents
    typedef struct packed {
        logic [DIM_W-1:0]    source_width;
        logic [DIM_W-1:0]    source_height;
        logic [SCALE_W-1:0]  scale_factor;
        logic [TURN_W-1:0]   quarter_turns;
        logic                vertical_mirror;
        logic                horizontal_mirror;
    } cfg_t;

    // Divider request and response
    typedef struct packed {
        logic                start;
        logic [SCALED_W-1:0] dividend;
        logic [SCALE_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SCALED_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/isrf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module isrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/isrf_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by row and column.
module isrf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  isrf_pkg::div_req_t req,
    output isrf_pkg::div_rsp_t rsp
);
    import isrf_pkg::*;

    localparam int CNT_W = $clog2(SCALED_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SCALE_W-1:0]  rem_reg, rem_next;
    logic [SCALED_W-1:0] quo_reg, quo_next;
    logic [SCALE_W-1:0]  dvsr_reg, dvsr_next;
    logic [SCALE_W:0]    trial;
    logic                fits;

    // one restoring step: bring down the next dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SCALED_W-1]};
        fits      = (trial >= {1'b0, dvsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SCALED_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = SCALE_W'(trial - {1'b0, dvsr_reg});
            end
            else
            begin
                rem_next = trial[SCALE_W-1:0];
            end
            quo_next = {quo_reg[SCALED_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/isrf_cfg.sv =====
// APB register file holding the geometry and transform settings.
module isrf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [isrf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [isrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [isrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output isrf_pkg::cfg_t                  cfg
);
    import isrf_pkg::*;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(256);
    localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(1);

    logic       wr_en;
    logic [2:0] idx;
    cfg_t       cfg_reg, cfg_next;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SRC_WIDTH:  cfg_next.source_width      = pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: cfg_next.source_height     = pwdata[DIM_W-1:0];
                REG_SCALE:      cfg_next.scale_factor      = pwdata[SCALE_W-1:0];
                REG_TURNS:      cfg_next.quarter_turns     = pwdata[TURN_W-1:0];
                REG_VMIRROR:    cfg_next.vertical_mirror   = pwdata[0];
                REG_HMIRROR:    cfg_next.horizontal_mirror = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width      <= WIDTH_RST;
            cfg_reg.source_height     <= HEIGHT_RST;
            cfg_reg.scale_factor      <= SCALE_RST;
            cfg_reg.quarter_turns     <= '0;
            cfg_reg.vertical_mirror   <= 1'b0;
            cfg_reg.horizontal_mirror <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read-back mux
    always_comb
    begin
        unique case (idx)
            REG_SRC_WIDTH:  prdata = APB_DATA_W'(cfg_reg.source_width);
            REG_SRC_HEIGHT: prdata = APB_DATA_W'(cfg_reg.source_height);
            REG_SCALE:      prdata = APB_DATA_W'(cfg_reg.scale_factor);
            REG_TURNS:      prdata = APB_DATA_W'(cfg_reg.quarter_turns);
            REG_VMIRROR:    prdata = APB_DATA_W'(cfg_reg.vertical_mirror);
            REG_HMIRROR:    prdata = APB_DATA_W'(cfg_reg.horizontal_mirror);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/image_scale_rotate_flip.sv =====
// Frame store with nearest-neighbour upscale, quarter-turn rotation and mirrors.
//
// Usage:
//  - req channel (req_valid / req_stall / req_item): command 0 stores pixel_value at
//    the next raster position of the source frame; command 1 asks for the pixel at
//    target_row / target_column of the transformed image.
//  - rsp channel (rsp_valid / rsp_stall / rsp_item): one item per read, none per load.
//    result_pixel is zero and outside_frame set when the coordinate is off the image.
//  - APB port: geometry, scale, turns and mirrors; write only while the block is idle.
// Sequence:
//  - A load computes the frame size product, then does the store write.
//  - A read goes from acceptance to the result register through the row and
//    column quotients, one after the other from one 13-step restoring divider,
//    then one address multiply and one frame store read; an off-image read
//    goes straight to the result.
//  - req_stall is high from acceptance until the item is finished.
// Reset clears the sequencer and the load position and sets the APB registers to
// their defaults; frame store contents are undefined until loaded. A stalled result
// waits in the output register; a finished read waits until it is taken.
module image_scale_rotate_flip #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SCALE  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  isrf_pkg::req_item_t             req_item,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output isrf_pkg::rsp_item_t             rsp_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [isrf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [isrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [isrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import isrf_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CALC_W  = (ADDR_W > FS_W) ? ADDR_W : FS_W;
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int SC_MAX  = (1 << SCALE_W) - 1;
    localparam int W_LIM   = (MAX_WIDTH  < DIM_MAX) ? MAX_WIDTH  : DIM_MAX;
    localparam int H_LIM   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int S_LIM   = (MAX_SCALE  < SC_MAX)  ? MAX_SCALE  : SC_MAX;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_SIZE    = 10'b00_0000_0010,
        S_WRITE   = 10'b00_0000_0100,
        S_DIMS    = 10'b00_0000_1000,
        S_MAP     = 10'b00_0001_0000,
        S_DIV_ROW = 10'b00_0010_0000,
        S_DIV_COL = 10'b00_0100_0000,
        S_ADDR    = 10'b00_1000_0000,
        S_READ    = 10'b01_0000_0000,
        S_RESULT  = 10'b10_0000_0000
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t              state_reg, state_next;
    req_item_t           item_reg, item_next;
    logic [ADDR_W-1:0]   lp_reg, lp_next;
    logic [FS_W-1:0]     fs_reg, fs_next;
    logic [SCALED_W-1:0] sw_reg, sw_next;
    logic [SCALED_W-1:0] sh_reg, sh_next;
    logic [SCALED_W-1:0] numc_reg, numc_next;
    logic [DIM_W-1:0]    qr_reg, qr_next;
    logic [DIM_W-1:0]    qc_reg, qc_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                out_reg, out_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_item_reg, rsp_item_next;

    logic [DIM_W-1:0]    w_eff, h_eff;
    logic [SCALE_W-1:0]  s_eff;
    logic [SCALED_W-1:0] ow, oh, row, col, row_m, col_m, r_map, c_map;
    logic                outside;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CALC_W-1:0]   wr_inc;
    logic [CALC_W-1:0]   addr_calc;
    logic                accept, rsp_free;
    logic                ram_we, ram_re;
    logic [PIX_W-1:0]    ram_rdata;

    // register file
    isrf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared divider
    isrf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // frame store
    isrf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (item_reg.pixel_value),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // saturated settings
    always_comb
    begin
        if (cfg.source_width == '0)
            w_eff = DIM_W'(1);
        else if (cfg.source_width > DIM_W'(W_LIM))
            w_eff = DIM_W'(W_LIM);
        else
            w_eff = cfg.source_width;

        if (cfg.source_height == '0)
            h_eff = DIM_W'(1);
        else if (cfg.source_height > DIM_W'(H_LIM))
            h_eff = DIM_W'(H_LIM);
        else
            h_eff = cfg.source_height;

        if (cfg.scale_factor == '0)
            s_eff = SCALE_W'(1);
        else if (cfg.scale_factor > SCALE_W'(S_LIM))
            s_eff = SCALE_W'(S_LIM);
        else
            s_eff = cfg.scale_factor;
    end

    // load address with wrap at the frame size
    always_comb
    begin
        if (CALC_W'(lp_reg) >= CALC_W'(fs_reg))
            wr_addr = '0;
        else
            wr_addr = lp_reg;
        wr_inc = CALC_W'(wr_addr) + CALC_W'(1);
    end

    // backward mapping: mirrors, then turns
    always_comb
    begin
        row   = SCALED_W'(item_reg.target_row);
        col   = SCALED_W'(item_reg.target_column);
        ow    = cfg.quarter_turns[0] ? sh_reg : sw_reg;
        oh    = cfg.quarter_turns[0] ? sw_reg : sh_reg;
        outside = (row >= oh) || (col >= ow);
        col_m = cfg.horizontal_mirror ? (ow - SCALED_W'(1) - col) : col;
        row_m = cfg.vertical_mirror   ? (oh - SCALED_W'(1) - row) : row;
        case (turn_t'(cfg.quarter_turns))
            TURN_90:
            begin
                r_map = col_m;
                c_map = sw_reg - SCALED_W'(1) - row_m;
            end
            TURN_180:
            begin
                r_map = sh_reg - SCALED_W'(1) - row_m;
                c_map = sw_reg - SCALED_W'(1) - col_m;
            end
            TURN_270:
            begin
                r_map = sh_reg - SCALED_W'(1) - col_m;
                c_map = row_m;
            end
            default:
            begin
                r_map = row_m;
                c_map = col_m;
            end
        endcase
    end

    assign addr_calc = CALC_W'(qr_reg) * CALC_W'(w_eff) + CALC_W'(qc_reg);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        lp_next        = lp_reg;
        fs_next        = fs_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        numc_next      = numc_reg;
        qr_next        = qr_reg;
        qc_next        = qc_reg;
        addr_next      = addr_reg;
        out_next       = out_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_item_next  = rsp_item_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_map;
        div_req.divisor  = s_eff;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req_item;
                    state_next = (req_item.command == CMD_LOAD) ? S_SIZE : S_DIMS;
                end
            end
            S_SIZE:
            begin
                fs_next    = FS_W'(w_eff) * FS_W'(h_eff);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                if (wr_inc >= CALC_W'(fs_reg))
                    lp_next = '0;
                else
                    lp_next = wr_inc[ADDR_W-1:0];
                state_next = S_IDLE;
            end
            S_DIMS:
            begin
                sw_next    = SCALED_W'(w_eff) * SCALED_W'(s_eff);
                sh_next    = SCALED_W'(h_eff) * SCALED_W'(s_eff);
                state_next = S_MAP;
            end
            S_MAP:
            begin
                out_next = outside;
                if (outside)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    numc_next     = c_map;
                    state_next    = S_DIV_ROW;
                end
            end
            S_DIV_ROW:
            begin
                if (div_rsp.done)
                begin
                    qr_next          = div_rsp.quotient[DIM_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = numc_reg;
                    state_next       = S_DIV_COL;
                end
            end
            S_DIV_COL:
            begin
                if (div_rsp.done)
                begin
                    qc_next    = div_rsp.quotient[DIM_W-1:0];
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                addr_next  = addr_calc[ADDR_W-1:0];
                state_next = S_READ;
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_item_next.result_pixel  = out_reg ? '0 : ram_rdata;
                    rsp_item_next.outside_frame = out_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lp_reg        <= lp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        fs_reg       <= fs_next;
        sw_reg       <= sw_next;
        sh_reg       <= sh_next;
        numc_reg     <= numc_next;
        qr_reg       <= qr_next;
        qc_reg       <= qc_next;
        addr_reg     <= addr_next;
        out_reg      <= out_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ===== tb/sv/image_scale_rotate_flip_tb.sv =====
// Self-checking testbench for the image scale, rotate and flip frame store.
`timescale 1ns / 100ps

module image_scale_rotate_flip_tb;
    import isrf_pkg::*;

    localparam int unsigned MAX_W           = 256;
    localparam int unsigned MAX_H           = 256;
    localparam int unsigned MAX_S           = 8;
    localparam int unsigned STORE_DEPTH     = MAX_W * MAX_H;
    localparam int unsigned RANDOM_ITEMS    = 2000;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned PRESSURE_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    // One row of the directed table: the item, and a typed result where one is given
    typedef struct packed {
        req_item_t item;
        logic      typed;
        rsp_item_t result;
    } directed_row_t;

    localparam int NUM_DIRECTED = 16;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{CMD_LOAD, 24'hFFFFFF, 11'h7FF, 11'h7FF}, 1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_LOAD, 24'h000000, 11'h000, 11'h000}, 1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_LOAD, 24'hA5A5A5, 11'h555, 11'h2AA}, 1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_LOAD, 24'h5A5A5A, 11'h2AA, 11'h555}, 1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_LOAD, 24'h123456, 11'h000, 11'h7FF}, 1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_READ, 24'h000000, 11'd0,   11'd0},   1'b1, '{24'hFFFFFF, 1'b0}},
        '{'{CMD_READ, 24'hFFFFFF, 11'd0,   11'd1},   1'b1, '{24'h000000, 1'b0}},
        '{'{CMD_READ, 24'h0F0F0F, 11'd0,   11'd2},   1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_READ, 24'hF0F0F0, 11'd0,   11'd3},   1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_READ, 24'h000000, 11'd0,   11'd4},   1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_READ, 24'h000000, 11'd256, 11'd0},   1'b1, '{24'h000000, 1'b1}},
        '{'{CMD_READ, 24'h000000, 11'd0,   11'd256}, 1'b1, '{24'h000000, 1'b1}},
        '{'{CMD_READ, 24'hFFFFFF, 11'd2047, 11'd2047}, 1'b1, '{24'h000000, 1'b1}},
        '{'{CMD_READ, 24'h000000, 11'd2047, 11'd0},  1'b1, '{24'h000000, 1'b1}},
        '{'{CMD_LOAD, 24'hFEDCBA, 11'h7FF, 11'h000}, 1'b0, '{24'h000000, 1'b0}},
        '{'{CMD_READ, 24'h000000, 11'd0,   11'd5},   1'b0, '{24'h000000, 1'b0}}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_item_t             req_item  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_item_t             rsp_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the block's state
    cfg_t        shadow_cfg;
    logic [23:0] frame_store [STORE_DEPTH];
    bit          written     [STORE_DEPTH];
    int unsigned load_position;

    rsp_item_t   expected_pixels [$];
    int unsigned error_count;
    int unsigned results_seen;
    int unsigned sender_quiet_left;

    image_scale_rotate_flip i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Effective source size, scale and output size of the transformed image
    function automatic void geometry(output int unsigned w, output int unsigned h,
                                     output int unsigned s, output int unsigned ow,
                                     output int unsigned oh);
        w  = clamp_to(shadow_cfg.source_width, MAX_W);
        h  = clamp_to(shadow_cfg.source_height, MAX_H);
        s  = clamp_to(shadow_cfg.scale_factor, MAX_S);
        ow = shadow_cfg.quarter_turns[0] ? h * s : w * s;
        oh = shadow_cfg.quarter_turns[0] ? w * s : h * s;
    endfunction

    // Raster store with wrap at the end of the frame
    function automatic void store_pixel(input logic [23:0] pixel);
        int unsigned w, h, s, ow, oh, addr;
        geometry(w, h, s, ow, oh);
        addr = load_position;
        if (addr >= w * h) addr = 0;
        frame_store[addr] = pixel;
        written[addr]     = 1'b1;
        addr++;
        if (addr >= w * h) addr = 0;
        load_position = addr;
    endfunction

    // Walk back from an output coordinate to a store address; 0 when off the image
    function automatic bit map_to_source(input int unsigned row, input int unsigned col,
                                         output int unsigned addr);
        int unsigned w, h, s, ow, oh, sw, sh, r, c;
        geometry(w, h, s, ow, oh);
        sw   = w * s;
        sh   = h * s;
        addr = 0;
        if (row >= oh || col >= ow) return 1'b0;
        if (shadow_cfg.horizontal_mirror) col = ow - 1 - col;
        if (shadow_cfg.vertical_mirror) row = oh - 1 - row;
        case (turn_t'(shadow_cfg.quarter_turns))
            TURN_90:  begin r = col;          c = sw - 1 - row; end
            TURN_180: begin r = sh - 1 - row; c = sw - 1 - col; end
            TURN_270: begin r = sh - 1 - col; c = row;          end
            default:  begin r = row;          c = col;          end
        endcase
        addr = (r / s) * w + c / s;
        return 1'b1;
    endfunction

    function automatic rsp_item_t predict_pixel(input int unsigned row, input int unsigned col);
        rsp_item_t   res;
        int unsigned addr;
        if (map_to_source(row, col, addr)) begin
            res.result_pixel  = frame_store[addr];
            res.outside_frame = 1'b0;
        end
        else begin
            res.result_pixel  = '0;
            res.outside_frame = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [23:0] random_pixel();
        case ($urandom_range(0, 15))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic int unsigned random_dim();
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 12);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 256;
            3:       return 511;
            default: return $urandom_range(257, 511);
        endcase
    endfunction

    // Random load or read; a read never lands on a store entry that was never loaded
    function automatic req_item_t random_item(input bit load_only);
        req_item_t   it;
        int unsigned w, h, s, ow, oh, row, col, addr, win_r, win_c;
        it.command       = CMD_LOAD;
        it.pixel_value   = random_pixel();
        it.target_row    = COORD_W'($urandom_range(0, 2047));
        it.target_column = COORD_W'($urandom_range(0, 2047));
        if (load_only || $urandom_range(0, 99) < 35) return it;
        geometry(w, h, s, ow, oh);
        win_r = (oh < 16) ? oh : 16;
        win_c = (ow < 16) ? ow : 16;
        for (int tries = 0; tries < 30; tries++) begin
            case ($urandom_range(0, 4))
                0: begin
                    row = $urandom_range(0, 2047);
                    col = $urandom_range(0, 2047);
                end
                1, 2: begin
                    row = $urandom_range(0, oh - 1);
                    col = $urandom_range(0, ow - 1);
                end
                default: begin
                    // corners of the output image reach the corners of the source frame
                    row = $urandom_range(0, win_r - 1);
                    col = $urandom_range(0, win_c - 1);
                    if ($urandom_range(0, 1)) row = oh - 1 - row;
                    if ($urandom_range(0, 1)) col = ow - 1 - col;
                end
            endcase
            if (!map_to_source(row, col, addr) || written[addr]) begin
                it.command       = CMD_READ;
                it.target_row    = COORD_W'(row);
                it.target_column = COORD_W'(col);
                return it;
            end
        end
        return it;
    endfunction

    // Offer one item, hold it until accepted, then maybe leave a gap
    task automatic send_item(input req_item_t it, input bit typed, input rsp_item_t result);
        int unsigned gap;
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (req_stall);
        if (it.command == CMD_LOAD)
            store_pixel(it.pixel_value);
        else if (typed)
            expected_pixels.push_back(result);
        else
            expected_pixels.push_back(predict_pixel(it.target_row, it.target_column));

        gap = 0;
        if (sender_quiet_left > 0) begin
            sender_quiet_left--;
        end
        else begin
            case ($urandom_range(0, 19)) inside
                [0:9]:   gap = 0;
                [10:15]: gap = $urandom_range(1, 3);
                [16:17]: gap = $urandom_range(4, 10);
                18:      gap = $urandom_range(20, 60);
                default: sender_quiet_left = $urandom_range(30, 150);
            endcase
        end
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  shadow_cfg.source_width      = value[DIM_W-1:0];
            REG_SRC_HEIGHT: shadow_cfg.source_height     = value[DIM_W-1:0];
            REG_SCALE:      shadow_cfg.scale_factor      = value[SCALE_W-1:0];
            REG_TURNS:      shadow_cfg.quarter_turns     = value[TURN_W-1:0];
            REG_VMIRROR:    shadow_cfg.vertical_mirror   = value[0];
            REG_HMIRROR:    shadow_cfg.horizontal_mirror = value[0];
            default: ;
        endcase
    endtask

    // Stop offering, wait for every read to come back, then let a late load finish
    task automatic drain_and_settle();
        req_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: check each accepted item, then choose the next stall
    initial begin : rsp_sink
        rsp_item_t   want;
        int unsigned stall_left;
        int unsigned go_left;
        bit          pressure_done;
        stall_left    = 0;
        go_left       = 0;
        pressure_done = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall) begin
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: result_pixel %06h outside_frame %0b",
                           rsp_item.result_pixel, rsp_item.outside_frame);
                    error_count++;
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (rsp_item.result_pixel !== want.result_pixel) begin
                        $error("result_pixel: expected %06h, actual %06h",
                               want.result_pixel, rsp_item.result_pixel);
                        error_count++;
                    end
                    if (rsp_item.outside_frame !== want.outside_frame) begin
                        $error("outside_frame: expected %0b, actual %0b",
                               want.outside_frame, rsp_item.outside_frame);
                        error_count++;
                    end
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (go_left > 0) begin
                go_left--;
                rsp_stall <= 1'b0;
            end
            else begin
                if (!pressure_done && results_seen >= 200) begin
                    // long hold-off so the block backs up onto its input
                    pressure_done = 1'b1;
                    stall_left    = PRESSURE_CYCLES;
                end
                else begin
                    case ($urandom_range(0, 19)) inside
                        [0:7]:   go_left    = $urandom_range(1, 12);
                        [8:13]:  stall_left = $urandom_range(1, 3);
                        [14:16]: stall_left = $urandom_range(4, 12);
                        17:      stall_left = $urandom_range(20, 60);
                        default: go_left    = $urandom_range(80, 250);
                    endcase
                end
                rsp_stall <= (stall_left != 0);
                if (stall_left != 0) stall_left--;
                else go_left--;
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence
    initial begin : main_seq
        int unsigned random_count;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned fill;
        int unsigned w, h, s, ow, oh;
        int unsigned cfg_w, cfg_h, cfg_s, cfg_q, cfg_v, cfg_m;

        error_count       = 0;
        results_seen      = 0;
        sender_quiet_left = 0;
        load_position     = 0;
        random_count      = 0;
        phase             = 0;
        shadow_cfg        = '{source_width: 9'd256, source_height: 9'd256,
                              scale_factor: 4'd1, quarter_turns: 2'd0,
                              vertical_mirror: 1'b0, horizontal_mirror: 1'b0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset geometry
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        drain_and_settle();

        // Random phases, each with its own geometry
        while (random_count < RANDOM_ITEMS) begin
            case (phase)
                0: begin  // largest image, every transform on
                    cfg_w = 256; cfg_h = 256; cfg_s = 8; cfg_q = 3; cfg_v = 1; cfg_m = 1;
                end
                1: begin  // smallest image
                    cfg_w = 1; cfg_h = 1; cfg_s = 1; cfg_q = 0; cfg_v = 0; cfg_m = 0;
                end
                2: begin  // zero and oversized values saturate
                    cfg_w = 0; cfg_h = 511; cfg_s = 0; cfg_q = 1; cfg_v = 1; cfg_m = 0;
                end
                3: begin
                    cfg_w = $urandom_range(257, 511); cfg_h = 0; cfg_s = 15;
                    cfg_q = 2; cfg_v = 0; cfg_m = 1;
                end
                default: begin
                    cfg_w = random_dim();
                    cfg_h = random_dim();
                    cfg_s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 4);
                    cfg_q = $urandom_range(0, 3);
                    cfg_v = $urandom_range(0, 1);
                    cfg_m = $urandom_range(0, 1);
                end
            endcase
            write_reg(REG_SRC_WIDTH, cfg_w);
            write_reg(REG_SRC_HEIGHT, cfg_h);
            write_reg(REG_SCALE, cfg_s);
            write_reg(REG_TURNS, cfg_q);
            write_reg(REG_VMIRROR, cfg_v);
            write_reg(REG_HMIRROR, cfg_m);

            // a run of loads first so that reads find data, then a mix
            geometry(w, h, s, ow, oh);
            fill      = (w * h < 48) ? w * h : 48;
            phase_len = $urandom_range(60, 140);
            for (int i = 0; i < phase_len; i++) begin
                send_item(random_item(i < fill), 1'b0, '0);
                random_count++;
            end
            drain_and_settle();
            phase++;
        end

        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/isrf_pkg.sv
sv/isrf_ram.sv
sv/isrf_div.sv
sv/isrf_cfg.sv
sv/image_scale_rotate_flip.sv
tb/sv/image_scale_rotate_flip_tb.sv
